// ===== sv/cvm_pkg.sv =====
`timescale 1ns / 1ps

package cvm_pkg;

  // sample and accumulator widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int SQ_W         = 2 * SAMPLE_WIDTH;
  localparam int ACC_W        = 44;
  localparam int MAG_W        = ACC_W / 2;
  localparam int REM_W        = MAG_W + 2;
  localparam int ROOT_STEPS   = MAG_W;
  localparam int CNT_W        = $clog2(ROOT_STEPS + 1);

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_REAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_IMAG = 1'd1;

  // controller to datapath
  typedef struct packed {
    logic load_root;
    logic step_root;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic accept_last;
    logic root_done;
    logic out_busy;
  } status_t;

endpackage

// ===== sv/complex_vector_magnitude.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// cfg     | in        | cfg_we              | cfg_index, cfg_data
// in      | in        | in_valid / in_ready | real_value, imag_value, last_element
// out     | out       | out_valid/out_ready | magnitude, sum_saturated
//
// one element per cycle is taken while a vector streams in
// after a last element: a flush state, 22 root steps of the shared
// shift-subtract unit and a handoff, and no element is taken until the
// handoff returns the sequencer to run
// a held result delays the handoff of the next root, and input waits with it
// rst is synchronous: sum, flag and config (both parts enabled) are restored

module complex_vector_magnitude (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [cvm_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic                                    cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [cvm_pkg::SAMPLE_WIDTH-1:0] real_value,
  input  logic signed [cvm_pkg::SAMPLE_WIDTH-1:0] imag_value,
  input  logic                                    last_element,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [cvm_pkg::MAG_W-1:0]               magnitude,
  output logic                                    sum_saturated
);

  cvm_pkg::cmd_t    cmd;
  cvm_pkg::status_t st;

  // sequencer
  cvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // squares, accumulator and root unit
  cvm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .real_value    (real_value),
    .imag_value    (imag_value),
    .last_element  (last_element),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .magnitude     (magnitude),
    .sum_saturated (sum_saturated)
  );

endmodule

// ===== sv/cvm_ctrl.sv =====
`timescale 1ns / 1ps

module cvm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  cvm_pkg::status_t st,
  output cvm_pkg::cmd_t    cmd,
  output logic            in_ready
);

  typedef enum logic [2:0] {
    S_RUN   = 3'b001,
    S_FLUSH = 3'b010,
    S_ROOT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd.load_root = 1'b0;
    cmd.step_root = 1'b0;
    cmd.emit      = 1'b0;
    in_ready      = 1'b0;
    case (state)
      S_RUN: begin
        in_ready = 1'b1;
        if (st.accept_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.load_root = 1'b1;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        if (!st.root_done) begin
          cmd.step_root = 1'b1;
        end else if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

endmodule

// ===== sv/cvm_datapath.sv =====
`timescale 1ns / 1ps

module cvm_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [cvm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic                                  cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [cvm_pkg::SAMPLE_WIDTH-1:0] real_value,
  input  logic signed [cvm_pkg::SAMPLE_WIDTH-1:0] imag_value,
  input  logic                                  last_element,
  input  logic                                  out_ready,
  input  cvm_pkg::cmd_t                         cmd,
  output cvm_pkg::status_t                      st,
  output logic                                  out_valid,
  output logic [cvm_pkg::MAG_W-1:0]             magnitude,
  output logic                                  sum_saturated
);

  logic                          use_real_part;
  logic                          use_imag_part;
  logic                          accept;
  logic                          pipe_valid;
  logic [cvm_pkg::SQ_W-1:0]      sq_re;
  logic [cvm_pkg::SQ_W-1:0]      sq_im;
  logic signed [cvm_pkg::SQ_W-1:0] prod_re;
  logic signed [cvm_pkg::SQ_W-1:0] prod_im;
  logic [cvm_pkg::ACC_W-1:0]     square_sum;
  logic                          overflow_seen;
  logic [cvm_pkg::ACC_W:0]       sum_total;
  logic                          sum_sat;
  logic [cvm_pkg::ACC_W-1:0]     square_sum_next;
  logic                          overflow_next;
  logic [cvm_pkg::ACC_W-1:0]     root_op;
  logic [cvm_pkg::REM_W-1:0]     root_rem;
  logic [cvm_pkg::MAG_W-1:0]     root;
  logic                          root_flag;
  logic [cvm_pkg::CNT_W-1:0]     root_cnt;
  logic [cvm_pkg::REM_W+1:0]     rem_shift;
  logic [cvm_pkg::REM_W+1:0]     trial;
  logic                          take;

  assign accept = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      use_real_part <= 1'b1;
      use_imag_part <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        cvm_pkg::REG_USE_REAL: use_real_part <= cfg_data;
        cvm_pkg::REG_USE_IMAG: use_imag_part <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // square stage
  assign prod_re = real_value * real_value;
  assign prod_im = imag_value * imag_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_re <= use_real_part ? prod_re : '0;
      sq_im <= use_imag_part ? prod_im : '0;
    end
  end

  // saturating accumulate of both squares
  assign sum_total = {1'b0, square_sum}
                   + {{(cvm_pkg::ACC_W + 1 - cvm_pkg::SQ_W){1'b0}}, sq_re}
                   + {{(cvm_pkg::ACC_W + 1 - cvm_pkg::SQ_W){1'b0}}, sq_im};
  assign sum_sat = sum_total >= {1'b0, cvm_pkg::ACC_MAX};

  always_comb begin
    square_sum_next = square_sum;
    overflow_next   = overflow_seen;
    if (pipe_valid) begin
      if (sum_sat) begin
        square_sum_next = cvm_pkg::ACC_MAX;
        overflow_next   = 1'b1;
      end else begin
        square_sum_next = sum_total[cvm_pkg::ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_root) begin
      square_sum    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      square_sum    <= square_sum_next;
      overflow_seen <= overflow_next;
    end
  end

  // one root bit per step, two operand bits in
  assign rem_shift = {root_rem, root_op[cvm_pkg::ACC_W-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign take      = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_cnt <= cvm_pkg::CNT_W'(cvm_pkg::ROOT_STEPS);
    end else if (cmd.load_root) begin
      root_cnt <= '0;
    end else if (cmd.step_root) begin
      root_cnt <= root_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_root) begin
      root_op   <= square_sum_next;
      root_rem  <= '0;
      root      <= '0;
      root_flag <= overflow_next;
    end else if (cmd.step_root) begin
      root_op  <= {root_op[cvm_pkg::ACC_W-3:0], 2'b00};
      root_rem <= take ? cvm_pkg::REM_W'(rem_shift - trial)
                       : rem_shift[cvm_pkg::REM_W-1:0];
      root     <= {root[cvm_pkg::MAG_W-2:0], take};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      magnitude     <= root;
      sum_saturated <= root_flag;
    end
  end

  // status to controller
  assign st.accept_last = accept && last_element;
  assign st.root_done   = root_cnt == cvm_pkg::CNT_W'(cvm_pkg::ROOT_STEPS);
  assign st.out_busy    = out_valid && !out_ready;

endmodule

// ===== bench/cvm_norm_checker.sv =====
`timescale 1ns / 1ps

module cvm_norm_checker
  import cvm_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic                           cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] real_value,
  input  logic signed [SAMPLE_WIDTH-1:0] imag_value,
  input  logic                           last_element,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [MAG_W-1:0]               magnitude,
  input  logic                           sum_saturated,
  output int                             mismatches,
  output int                             results_due
);

  // one predicted norm per finished vector
  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             saturated;
  } norm_t;

  norm_t            norm_q[$];
  logic             use_real;
  logic             use_imag;
  logic [ACC_W-1:0] sq_sum;
  logic             sat_seen;

  // square of a two's complement sample, most negative value included
  function automatic logic [SQ_W-1:0] square_of(input logic signed [SAMPLE_WIDTH-1:0] s);
    logic [SAMPLE_WIDTH:0] m;
    m = s[SAMPLE_WIDTH-1] ? -{s[SAMPLE_WIDTH-1], s} : {1'b0, s};
    return SQ_W'(m) * SQ_W'(m);
  endfunction

  // floored square root, one result bit at a time from the top
  function automatic logic [MAG_W-1:0] floor_root(input logic [ACC_W-1:0] v);
    logic [MAG_W-1:0] r;
    logic [MAG_W-1:0] trial;
    r = '0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = r | (MAG_W'(1) << b);
      if (ACC_W'(trial) * ACC_W'(trial) <= v) r = trial;
    end
    return r;
  endfunction

  // saturating add into the running sum, reaching the top counts as saturation
  task automatic add_square(input logic [SQ_W-1:0] sq);
    if (ACC_W'(sq) >= ACC_MAX - sq_sum) begin
      sq_sum   = ACC_MAX;
      sat_seen = 1'b1;
    end else begin
      sq_sum = sq_sum + ACC_W'(sq);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // outputs first, so a result is never matched against an item of the same edge
  always @(posedge clk) begin
    norm_t want;
    if (rst) begin
      use_real = 1'b1;
      use_imag = 1'b1;
      sq_sum   = '0;
      sat_seen = 1'b0;
      norm_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (norm_q.size() == 0) begin
          report_mismatch("unexpected result, magnitude", magnitude, 0);
        end else begin
          want = norm_q.pop_front();
          if (magnitude !== want.magnitude)
            report_mismatch("magnitude", magnitude, want.magnitude);
          if (sum_saturated !== want.saturated)
            report_mismatch("sum_saturated", sum_saturated, want.saturated);
        end
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_USE_REAL: use_real = cfg_data;
          REG_USE_IMAG: use_imag = cfg_data;
          default: ;
        endcase
      end

      // accumulate the item, close the vector on its last element
      if (in_valid && in_ready) begin
        if (use_real) add_square(square_of(real_value));
        if (use_imag) add_square(square_of(imag_value));
        if (last_element) begin
          want.magnitude = floor_root(sq_sum);
          want.saturated = sat_seen;
          norm_q.push_back(want);
          sq_sum   = '0;
          sat_seen = 1'b0;
        end
      end
    end
    results_due = norm_q.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cvm_pkg::*;

  localparam int S_MIN        = -32768;
  localparam int S_MAX        = 32767;
  localparam int ROOT_LATENCY = 30;
  localparam int PHASE_ITEMS  = 120;
  localparam int FULL_STEPS   = 40;

  logic                           clk          = 1'b0;
  logic                           rst          = 1'b1;
  logic                           cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index    = REG_USE_REAL;
  logic                           cfg_data     = 1'b0;
  logic                           in_valid     = 1'b0;
  logic                           in_ready;
  logic signed [SAMPLE_WIDTH-1:0] real_value   = '0;
  logic signed [SAMPLE_WIDTH-1:0] imag_value   = '0;
  logic                           last_element = 1'b0;
  logic                           out_valid;
  logic                           out_ready    = 1'b0;
  logic [MAG_W-1:0]               magnitude;
  logic                           sum_saturated;

  int   mismatches;
  int   results_due;
  int   sent  = 0;
  logic burst = 1'b0;

  // per-phase register settings for the random part
  logic phase_real[5] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
  logic phase_imag[5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  complex_vector_magnitude u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .real_value   (real_value),
    .imag_value   (imag_value),
    .last_element (last_element),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .magnitude    (magnitude),
    .sum_saturated(sum_saturated)
  );

  cvm_norm_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .real_value   (real_value),
    .imag_value   (imag_value),
    .last_element (last_element),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .magnitude    (magnitude),
    .sum_saturated(sum_saturated),
    .mismatches   (mismatches),
    .results_due  (results_due)
  );

  // sample values biased toward the extremes
  function automatic int draw_sample();
    case ($urandom_range(0, 7))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return 0;
      3:       return int'($urandom_range(0, 15)) - 8;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // one element, called at a falling edge, returns at the falling edge after acceptance
  task automatic send_element(input int re, input int im, input logic lst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    real_value   <= re[SAMPLE_WIDTH-1:0];
    imag_value   <= im[SAMPLE_WIDTH-1:0];
    last_element <= lst;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    sent++;
  endtask

  // stop the stream, let every norm come out and the root unit settle
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (ROOT_LATENCY) @(negedge clk);
  endtask

  task automatic set_parts(input logic re_on, input logic im_on);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_USE_REAL;
    cfg_data  <= re_on;
    @(negedge clk);
    cfg_index <= REG_USE_IMAG;
    cfg_data  <= im_on;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly short vectors, now and then a longer one
  task automatic random_vector();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++)
      send_element(draw_sample(), draw_sample(), i == len - 1);
  endtask

  // full-scale elements followed by random ones
  task automatic long_vector(input int n_peak, input int n_tail);
    int total;
    total = n_peak + n_tail;
    for (int i = 0; i < total; i++) begin
      if (i < n_peak) send_element(S_MIN, S_MIN, i == total - 1);
      else send_element(draw_sample(), draw_sample(), i == total - 1);
    end
  endtask

  // output side: stall while a result is waiting, or take it at once
  initial begin
    int n;
    @(negedge clk);
    forever begin
      n = burst ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (out_valid !== 1'b1);
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // both parts, as after reset
    send_element(0, 0, 1'b1);
    send_element(S_MAX, S_MIN, 1'b1);
    send_element(S_MIN, S_MIN, 1'b1);
    send_element(-1, 1, 1'b0);
    send_element(1, -1, 1'b1);
    send_element(S_MAX, 0, 1'b0);
    send_element(0, S_MAX, 1'b0);
    send_element(-12345, 23456, 1'b1);

    // real part only
    set_parts(1'b1, 1'b0);
    send_element(12345, S_MIN, 1'b1);
    send_element(S_MIN, S_MAX, 1'b1);

    // imaginary part only
    set_parts(1'b0, 1'b1);
    send_element(S_MIN, 5, 1'b1);
    send_element(7, S_MIN, 1'b0);
    send_element(S_MAX, -3, 1'b1);

    // no part selected, norm is zero
    set_parts(1'b0, 1'b0);
    send_element(S_MAX, S_MAX, 1'b0);
    send_element(S_MIN, S_MIN, 1'b1);

    // long full-scale vectors, then a short one to see the sum cleared
    set_parts(1'b1, 1'b1);
    long_vector(FULL_STEPS, 0);
    long_vector(FULL_STEPS, 5);
    send_element(3, 4, 1'b1);

    // random vectors under each setting, one phase without idling
    for (int p = 0; p < 5; p++) begin
      int start;
      set_parts(phase_real[p], phase_imag[p]);
      burst = (p == 1);
      start = sent;
      while (sent - start < PHASE_ITEMS) random_vector();
    end
    burst = 1'b0;

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== complex_vector_magnitude.f =====
sv/cvm_pkg.sv
sv/cvm_ctrl.sv
sv/cvm_datapath.sv
sv/complex_vector_magnitude.sv
bench/cvm_norm_checker.sv
bench/tb.sv
